// ----- design/bcs_pkg.sv -----
// ----------------------------------------------------------------------------
// bcs_pkg
// shared types, codes and defaults of the bounded call stack engine
// ----------------------------------------------------------------------------
package bcs_pkg;

    localparam int DEPTH_DEF    = 256;
    localparam int NUM_REGS_DEF = 4;

    localparam logic [15:0] WORD_BYTES = 16'h0008;

    localparam logic [15:0] BOTTOM_RST = 16'd2040;
    localparam logic [15:0] LIMIT_RST  = 16'd0;
    localparam logic [15:0] START_RST  = 16'd2040;

    localparam logic [1:0] CMD_PUSH_IMM = 2'd0;
    localparam logic [1:0] CMD_PUSH_REG = 2'd1;
    localparam logic [1:0] CMD_POP      = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam logic [1:0] CFG_BOTTOM = 2'd0;
    localparam logic [1:0] CFG_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_START  = 2'd2;

    typedef enum logic [1:0] {
        K_NOP,
        K_PUSH_IMM,
        K_PUSH_REG,
        K_POP
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  reg_index;
        logic [63:0] imm;
    } t_item;

    typedef struct packed {
        logic [15:0] bottom;
        logic [15:0] limit;
        logic [15:0] start;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [15:0] pointer;
        logic [63:0] value;
    } t_result;

endpackage

// ----- design/bcs_ram.sv -----
// ----------------------------------------------------------------------------
// bcs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bcs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/bcs_front.sv -----
// ----------------------------------------------------------------------------
// bcs_front
// accepts command beats, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module bcs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_cmd,
    input  logic [1:0]    i_reg_index,
    input  logic [63:0]   i_imm_value,
    output logic          o_busy,
    output logic          o_q_valid,
    output bcs_pkg::t_item o_q_item,
    input  logic          i_q_take
);
    import bcs_pkg::*;

    t_item      r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       push_q;
    logic       pop_q;
    t_kind      kind;

    always_comb begin
        case (i_cmd)
            CMD_PUSH_IMM: kind = K_PUSH_IMM;
            CMD_PUSH_REG: kind = K_PUSH_REG;
            CMD_POP:      kind = K_POP;
            default:      kind = K_NOP;
        endcase
    end

    assign o_busy    = (r_count == 2'd2);
    assign push_q    = i_start && !o_busy;
    assign o_q_valid = (r_count != 2'd0);
    assign pop_q     = i_q_take && o_q_valid;
    assign o_q_item  = r_q[r_rd];

    always_comb begin
        n_count = r_count;
        if (push_q && !pop_q) begin
            n_count = r_count + 2'd1;
        end else if (pop_q && !push_q) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push_q) begin
                r_wr <= !r_wr;
            end
            if (pop_q) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_q) begin
            r_q[r_wr] <= '{kind: kind, reg_index: i_reg_index, imm: i_imm_value};
        end
    end

endmodule

// ----- design/bcs_back.sv -----
// ----------------------------------------------------------------------------
// bcs_back
// executes queued commands against the pointer, registers and stack ram
// ----------------------------------------------------------------------------
module bcs_back #(
    parameter int DEPTH    = bcs_pkg::DEPTH_DEF,
    parameter int NUM_REGS = bcs_pkg::NUM_REGS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bcs_pkg::t_cfg    i_cfg,
    input  logic             i_load_ptr,
    input  logic [15:0]      i_load_value,
    input  logic             i_q_valid,
    input  bcs_pkg::t_item   i_q_item,
    output logic             o_q_take,
    output bcs_pkg::t_result o_res
);
    import bcs_pkg::*;

    localparam int AW = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } t_state;

    t_state      r_state;
    t_state      n_state;
    logic [15:0] r_ptr;
    logic [15:0] n_ptr;
    logic [63:0] r_regs [NUM_REGS];
    logic [63:0] n_regs [NUM_REGS];
    t_result     r_res;
    t_result     n_res;
    logic [1:0]  r_pend_ri;
    logic [1:0]  n_pend_ri;
    logic        r_pend_oor;
    logic        n_pend_oor;

    logic [15:0] push_ptr;
    logic [15:0] push_diff;
    logic [15:0] pop_diff;
    logic        push_in_range;
    logic        pop_in_range;
    logic        wr_en;
    logic [63:0] wr_data;
    logic        rd_en;
    logic [63:0] rd_data;
    logic [63:0] word;
    logic        ri_ok;

    function automatic logic [63:0] reg_read(input logic [1:0] idx);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < NUM_REGS; i++) begin
            if (32'(idx) == 32'(i)) begin
                v = r_regs[i];
            end
        end
        return v;
    endfunction

    assign push_ptr      = r_ptr - WORD_BYTES;
    assign push_diff     = i_cfg.bottom - push_ptr;
    assign pop_diff      = i_cfg.bottom - r_ptr;
    assign push_in_range = 32'(push_diff[15:3]) < DEPTH;
    assign pop_in_range  = 32'(pop_diff[15:3]) < DEPTH;
    assign wr_data       = (i_q_item.kind == K_PUSH_IMM) ? i_q_item.imm
                                                         : reg_read(i_q_item.reg_index);
    assign word          = r_pend_oor ? 64'd0 : rd_data;
    assign ri_ok         = 32'(r_pend_ri) < NUM_REGS;

    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_regs     = r_regs;
        n_res      = r_res;
        n_res.valid = 1'b0;
        n_pend_ri  = r_pend_ri;
        n_pend_oor = r_pend_oor;
        o_q_take   = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        if (i_load_ptr) begin
            n_ptr = i_load_value;
        end
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_take      = 1'b1;
                    n_res.valid   = 1'b1;
                    n_res.status  = ST_DONE;
                    n_res.pointer = r_ptr;
                    n_res.value   = reg_read(i_q_item.reg_index);
                    case (i_q_item.kind)
                        K_PUSH_IMM, K_PUSH_REG: begin
                            if (r_ptr == i_cfg.limit) begin
                                n_res.status = ST_OVERFLOW;
                            end else begin
                                n_ptr         = push_ptr;
                                wr_en         = push_in_range;
                                n_res.pointer = push_ptr;
                            end
                        end
                        K_POP: begin
                            if (r_ptr == i_cfg.bottom) begin
                                n_res.status = ST_UNDERFLOW;
                            end else begin
                                n_res.valid = 1'b0;
                                rd_en       = 1'b1;
                                n_pend_ri   = i_q_item.reg_index;
                                n_pend_oor  = !pop_in_range;
                                n_state     = S_POP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                for (int i = 0; i < NUM_REGS; i++) begin
                    if (32'(r_pend_ri) == 32'(i)) begin
                        n_regs[i] = word;
                    end
                end
                n_ptr         = r_ptr + WORD_BYTES;
                n_res.valid   = 1'b1;
                n_res.status  = ST_DONE;
                n_res.pointer = r_ptr + WORD_BYTES;
                n_res.value   = ri_ok ? word : 64'd0;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= START_RST;
            r_res   <= '0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= 64'(20 + 11 * i);
            end
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_res   <= n_res;
            r_regs  <= n_regs;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_ri  <= n_pend_ri;
        r_pend_oor <= n_pend_oor;
    end

    bcs_ram #(
        .WIDTH(64),
        .DEPTH(DEPTH)
    ) u_stack_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(push_diff[AW+2:3]),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(pop_diff[AW+2:3]),
        .o_rd_data(rd_data)
    );

    assign o_res = r_res;

`ifndef SYNTHESIS
    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP |=> o_res.valid)
        else $error("pop did not produce a result beat");
    a_overflow_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.status == ST_OVERFLOW |-> o_res.pointer == i_cfg.limit)
        else $error("overflow reported away from the limit");
    a_underflow_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.status == ST_UNDERFLOW |-> o_res.pointer == i_cfg.bottom)
        else $error("underflow reported away from the bottom");
    a_ram_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en))
        else $error("stack ram written and read in one cycle");
    a_no_take_in_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP |-> !o_q_take)
        else $error("queue drained while a pop is pending");
`endif

endmodule

// ----- design/bounded_call_stack_engine.sv -----
// ----------------------------------------------------------------------------
// bounded_call_stack_engine
// downward-growing stack of 64-bit words with a bounded pointer and
// general registers, driven by push and pop command beats
// ----------------------------------------------------------------------------
// usage:
//   a command beat is taken when start is high and busy is low; busy rises
//   only when the two-entry command queue is full.
//   each command gives one result beat: o_result_valid is high for exactly
//   one cycle with status, pointer and selected register value.
//   with the queue empty, a push, fail or no-op command goes from the queue
//   straight into the result register; a successful pop first passes the
//   S_POP state, which waits on the registered stack ram read.
//   the execution stage can take a new command right after a push; a pop
//   holds off the next command while it waits in S_POP on the ram read.
//   configuration goes through the apb port (bottom at 0x0, limit at 0x4,
//   start pointer at 0x8); writing the start pointer reloads the pointer.
//   reset empties the queue, loads the default pointer and register values;
//   stack ram contents are undefined until written. results cannot be held
//   off by the receiver.
// ----------------------------------------------------------------------------
module bounded_call_stack_engine #(
    parameter int DEPTH    = bcs_pkg::DEPTH_DEF,
    parameter int NUM_REGS = bcs_pkg::NUM_REGS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [1:0]  i_reg_index,
    input  logic [63:0] i_imm_value,
    output logic        o_result_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_pointer_now,
    output logic [63:0] o_reg_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bcs_pkg::*;

    t_cfg    r_cfg;
    logic    cfg_wr;
    logic    load_ptr;
    logic    q_valid;
    logic    q_take;
    t_item   q_item;
    t_result res;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign load_ptr = cfg_wr && (paddr[3:2] == CFG_START);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bottom <= BOTTOM_RST;
            r_cfg.limit  <= LIMIT_RST;
            r_cfg.start  <= START_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                CFG_BOTTOM: r_cfg.bottom <= pwdata[15:0];
                CFG_LIMIT:  r_cfg.limit  <= pwdata[15:0];
                CFG_START:  r_cfg.start  <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            CFG_BOTTOM: prdata = {16'd0, r_cfg.bottom};
            CFG_LIMIT:  prdata = {16'd0, r_cfg.limit};
            CFG_START:  prdata = {16'd0, r_cfg.start};
            default:    prdata = 32'd0;
        endcase
    end

    bcs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_cmd      (i_cmd),
        .i_reg_index(i_reg_index),
        .i_imm_value(i_imm_value),
        .o_busy     (busy),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_take   (q_take)
    );

    bcs_back #(
        .DEPTH   (DEPTH),
        .NUM_REGS(NUM_REGS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_load_ptr  (load_ptr),
        .i_load_value(pwdata[15:0]),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_take    (q_take),
        .o_res       (res)
    );

    assign o_result_valid = res.valid;
    assign o_status       = res.status;
    assign o_pointer_now  = res.pointer;
    assign o_reg_value    = res.value;

endmodule

// ----- tb/tb_bounded_call_stack_engine.sv -----
// ----------------------------------------------------------------------------
// tb_bounded_call_stack_engine
// self-checking bench for the bounded call stack engine: directed push, pop,
// overflow, underflow, wrap and register map cases, then randomised phases
// under many stack bounds with bursty command beats, every result beat
// compared against an in-bench stack predictor
// ----------------------------------------------------------------------------
module tb_bounded_call_stack_engine;

    import bcs_pkg::*;

    localparam int          ROWS        = DEPTH_DEF;
    localparam int          GPRS        = NUM_REGS_DEF;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam logic [1:0]  CFG_NONE    = 2'd3;
    localparam int          PHASES      = 16;
    localparam int          PHASE_BEATS = 90;
    localparam int          CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] pointer;
        logic [63:0] value;
    } t_stack_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        start         = 1'b0;
    logic [1:0]  i_cmd         = '0;
    logic [1:0]  i_reg_index   = '0;
    logic [63:0] i_imm_value   = '0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic        busy;
    logic        o_result_valid;
    logic [1:0]  o_status;
    logic [15:0] o_pointer_now;
    logic [63:0] o_reg_value;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [15:0] cfg_bottom;
    logic [15:0] cfg_limit;
    logic [15:0] cfg_start;
    logic [15:0] sp;
    logic [63:0] stack_mem [ROWS];
    logic        row_written [ROWS];
    logic [63:0] gpr [GPRS];

    t_stack_result stack_results_q [$];
    t_stack_result got_exp;

    int fails;
    int cycles;
    int n_push;
    int n_pop;
    int n_nop;
    int n_overflow;
    int n_underflow;
    int n_checked;

    bounded_call_stack_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_reg_index    (i_reg_index),
        .i_imm_value    (i_imm_value),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_pointer_now  (o_pointer_now),
        .o_reg_value    (o_reg_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycles,
                     stack_results_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (stack_results_q.size() == 0) begin
                $error("result beat with nothing outstanding: status %0d pointer %h",
                       o_status, o_pointer_now);
                fails++;
            end else begin
                got_exp = stack_results_q.pop_front();
                n_checked++;
                if (o_status !== got_exp.status) begin
                    $error("status: expected %0d, actual %0d", got_exp.status, o_status);
                    fails++;
                end
                if (o_pointer_now !== got_exp.pointer) begin
                    $error("pointer_now: expected %h, actual %h", got_exp.pointer,
                           o_pointer_now);
                    fails++;
                end
                if (o_reg_value !== got_exp.value) begin
                    $error("reg_value: expected %h, actual %h", got_exp.value, o_reg_value);
                    fails++;
                end
            end
        end
    end

    function automatic logic [12:0] row_at(input logic [15:0] p);
        logic [15:0] diff;
        diff = cfg_bottom - p;
        return diff[15:3];
    endfunction

    function automatic void reset_stack_model();
        cfg_bottom = BOTTOM_RST;
        cfg_limit  = LIMIT_RST;
        cfg_start  = START_RST;
        sp         = START_RST;
        for (int i = 0; i < ROWS; i++) begin
            stack_mem[i]   = '0;
            row_written[i] = 1'b0;
        end
        for (int i = 0; i < GPRS; i++)
            gpr[i] = 64'(20 + 11 * i);
    endfunction

    function automatic void advance_stack(input logic [1:0] cmd, input logic [1:0] ri,
                                          input logic [63:0] imm);
        t_stack_result r;
        logic [12:0]   row;
        logic [63:0]   word;
        r.status = ST_DONE;
        if (cmd == CMD_PUSH_IMM || cmd == CMD_PUSH_REG) begin
            n_push++;
            if (sp == cfg_limit) begin
                r.status = ST_OVERFLOW;
                n_overflow++;
            end else begin
                word = (cmd == CMD_PUSH_IMM) ? imm : gpr[ri];
                sp   = sp - WORD_BYTES;
                row  = row_at(sp);
                if (row < ROWS) begin
                    stack_mem[row]   = word;
                    row_written[row] = 1'b1;
                end
            end
        end else if (cmd == CMD_POP) begin
            n_pop++;
            if (sp == cfg_bottom) begin
                r.status = ST_UNDERFLOW;
                n_underflow++;
            end else begin
                row     = row_at(sp);
                gpr[ri] = (row < ROWS) ? stack_mem[row] : 64'd0;
                sp      = sp + WORD_BYTES;
            end
        end else begin
            n_nop++;
        end
        r.pointer = sp;
        r.value   = gpr[ri];
        stack_results_q.push_back(r);
    endfunction

    // called at a falling edge, returns at a falling edge with start still high
    task automatic send_cmd(input logic [1:0] cmd, input logic [1:0] ri,
                            input logic [63:0] imm);
        start       <= 1'b1;
        i_cmd       <= cmd;
        i_reg_index <= ri;
        i_imm_value <= imm;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        advance_stack(cmd, ri, imm);
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input int n);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (stack_results_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] value);
        logic [31:0] junk;
        junk    = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk[31:16], value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        case (idx)
            CFG_BOTTOM: cfg_bottom = value;
            CFG_LIMIT:  cfg_limit  = value;
            CFG_START: begin
                cfg_start = value;
                sp        = value;
            end
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_read_check(input logic [1:0] idx, input logic [15:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata[15:0] !== want) begin
            $error("prdata at %h: expected %h, actual %h", {idx, 2'b00}, want, prdata[15:0]);
            fails++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] b, input logic [15:0] l,
                              input logic [15:0] s);
        wait_drained();
        cfg_write(CFG_BOTTOM, b);
        cfg_write(CFG_LIMIT, l);
        cfg_write(CFG_START, s);
        cfg_read_check(CFG_BOTTOM, cfg_bottom);
        cfg_read_check(CFG_LIMIT, cfg_limit);
        cfg_read_check(CFG_START, cfg_start);
    endtask

    // defaults after reset: empty pop, both push kinds, lifo order, unused command
    task automatic test_basic_push_pop();
        send_cmd(CMD_POP, 2'd0, '0);
        send_cmd(CMD_PUSH_IMM, 2'd0, '1);
        send_cmd(CMD_PUSH_IMM, 2'd1, '0);
        send_cmd(CMD_PUSH_REG, 2'd1, '0);
        send_cmd(CMD_PUSH_REG, 2'd3, '0);
        send_cmd(CMD_UNUSED, 2'd2, 64'h0123_4567_89ab_cdef);
        send_cmd(CMD_POP, 2'd0, '0);
        send_cmd(CMD_POP, 2'd2, '0);
        send_cmd(CMD_POP, 2'd1, '0);
        send_cmd(CMD_POP, 2'd3, '0);
        send_cmd(CMD_POP, 2'd0, '0);
    endtask

    task automatic test_overflow();
        set_config(16'd2040, 16'd2024, 16'd2040);
        send_cmd(CMD_PUSH_IMM, 2'd0, 64'h5555_5555_5555_5555);
        send_cmd(CMD_PUSH_REG, 2'd2, '0);
        send_cmd(CMD_PUSH_IMM, 2'd1, 64'hdead_beef_0000_0001);
        send_cmd(CMD_POP, 2'd1, '0);
        send_cmd(CMD_POP, 2'd3, '0);
    endtask

    // pointer wrapping below zero and rows beyond the stack ram
    task automatic test_wrap_and_out_of_range();
        set_config(16'd2040, 16'd8, 16'd0);
        send_cmd(CMD_PUSH_IMM, 2'd0, 64'hffff_0000_ffff_0000);
        send_cmd(CMD_POP, 2'd2, '0);
        set_config(16'd0, 16'd65528, 16'd0);
        send_cmd(CMD_PUSH_IMM, 2'd3, 64'haaaa_aaaa_aaaa_aaaa);
        send_cmd(CMD_PUSH_REG, 2'd0, '0);
        send_cmd(CMD_POP, 2'd3, '0);
        send_cmd(CMD_POP, 2'd1, '0);
    endtask

    // unmapped register slot and bounds that are not word aligned
    task automatic test_register_map();
        wait_drained();
        cfg_write(CFG_NONE, 16'hffff);
        set_config(16'd2044, 16'd2020, 16'd2044);
        send_cmd(CMD_PUSH_REG, 2'd0, '0);
        send_cmd(CMD_POP, 2'd1, '0);
        send_cmd(CMD_UNUSED, 2'd3, '1);
    endtask

    task automatic test_random_phases();
        logic [15:0] b;
        logic [15:0] l;
        logic [15:0] s;
        logic [15:0] span;
        logic [31:0] r;
        logic [1:0]  cmd;
        logic [1:0]  ri;
        logic [63:0] imm;
        logic [12:0] row;
        int          push_pct;
        int          burst;
        int          pick;
        bit          no_gaps;
        for (int ph = 0; ph < PHASES; ph++) begin
            r    = $urandom;
            b    = {r[15:3], 3'b000};
            span = 16'($urandom_range(1, 40) * 8);
            l    = b - span;
            s    = b;
            case (ph)
                0: begin b = 16'd0;     l = 16'd65528; s = 16'd0;     end
                1: begin b = 16'd65528; l = 16'd0;     s = 16'd65528; end
                2: begin b = 16'd65535; l = 16'd65471; s = 16'd65535; end
                3: begin b = 16'd0;     l = 16'd0;     s = 16'd0;     end
                default: begin
                    pick = $urandom_range(0, 9);
                    if (pick >= 6 && pick <= 7) begin
                        l = b - 16'd2040;
                    end else if (pick == 8) begin
                        r = $urandom;
                        b = r[15:0];
                        l = r[31:16];
                        r = $urandom;
                        s = r[15:0];
                    end else if (pick == 9) begin
                        s = b + 16'($urandom_range(1, 4) * 8);
                    end
                end
            endcase
            set_config(b, l, s);
            push_pct = $urandom_range(35, 65);
            no_gaps  = (ph % 4 == 1);
            burst    = $urandom_range(1, 20);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                pick = $urandom_range(0, 99);
                ri   = 2'($urandom_range(0, 3));
                imm  = {$urandom, $urandom};
                if (pick < 4)
                    imm = (pick < 2) ? '0 : '1;
                if (pick >= 95)
                    cmd = CMD_UNUSED;
                else if (pick < push_pct)
                    cmd = (pick % 2 == 0) ? CMD_PUSH_IMM : CMD_PUSH_REG;
                else
                    cmd = CMD_POP;
                // never pop a ram row that holds nothing yet
                row = row_at(sp);
                if (cmd == CMD_POP && sp != cfg_bottom && row < ROWS && !row_written[row])
                    cmd = CMD_PUSH_IMM;
                send_cmd(cmd, ri, imm);
                if (!no_gaps) begin
                    burst--;
                    if (burst == 0) begin
                        idle_gap($urandom_range(1, 6));
                        burst = $urandom_range(1, 20);
                    end
                end
            end
        end
    endtask

    initial begin
        fails       = 0;
        cycles      = 0;
        n_push      = 0;
        n_pop       = 0;
        n_nop       = 0;
        n_overflow  = 0;
        n_underflow = 0;
        n_checked   = 0;
        reset_stack_model();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_basic_push_pop();
        test_overflow();
        test_wrap_and_out_of_range();
        test_register_map();
        test_random_phases();

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("%0d command beats checked: %0d push, %0d pop, %0d unused",
                 n_checked, n_push, n_pop, n_nop);
        $display("%0d overflow and %0d underflow results over %0d bound settings",
                 n_overflow, n_underflow, PHASES + 5);
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
design/bcs_pkg.sv
design/bcs_ram.sv
design/bcs_front.sv
design/bcs_back.sv
design/bounded_call_stack_engine.sv
tb/tb_bounded_call_stack_engine.sv
